// ----- src/sorted_expiry_timer_queue_assert.svh -----
// Assertion macros for the timer queue.
`ifndef SORTED_EXPIRY_TIMER_QUEUE_ASSERT_SVH
`define SORTED_EXPIRY_TIMER_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define STQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STQ_ASSERT_IMPL(label, ante, cons, msg)
`define STQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- src/stq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;
  localparam logic [2:0] CmdAdd    = 3'd0;
  localparam logic [2:0] CmdSet    = 3'd1;
  localparam logic [2:0] CmdCancel = 3'd2;
  localparam logic [2:0] CmdRemove = 3'd3;
  localparam logic [2:0] CmdQuery  = 3'd4;
  localparam logic [2:0] CmdFire   = 3'd5;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSlot  = 2'd1;
  localparam logic [1:0] StBadSlot = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone   = 4'd0,
    OpLatch  = 4'd1,  // capture the command word
    OpScan   = 4'd2,  // one step of a walk over the sorted list
    OpShift  = 4'd3,  // one step of a list shift
    OpPlace  = 4'd4,  // write the new entry
    OpFinish = 4'd5   // emit the result word
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   fire_emit;   // emit a fired word at the head
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic found;
    logic head_expired;
  } dp_stat_t;
endpackage
`default_nettype wire

// ----- src/sorted_expiry_timer_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                        Handshake
// command   cmd_i timer_id_i delay_ms_i now_ms_i         start_i && !busy_o
// result    status_o slot_id_o timeout_ms_o queue_empty_o strobe_o, one cycle
//                fired_o last_o
// After the accept, add, query, unused codes, fire with no expired head, bad
// slots and cancel or remove of an unarmed slot report straight from decode;
// cancel or remove of an armed timer walks to its entry and closes the gap;
// set of an unarmed slot walks to the insertion point, opens a gap, places;
// set of an armed one does both. Fire disarms and reports each expired head.
// Reset clears the allocation and active flags and the count at once.
// The receiver cannot stall; busy_o falls by the cycle after the last word.
`include "sorted_expiry_timer_queue_assert.svh"
module sorted_expiry_timer_queue import stq_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [3:0]  timer_id_i,
  input  wire logic [31:0] delay_ms_i,
  input  wire logic [47:0] now_ms_i,
  output logic             strobe_o,
  output logic [1:0]       status_o,
  output logic [3:0]       slot_id_o,
  output logic [31:0]      timeout_ms_o,
  output logic             queue_empty_o,
  output logic             fired_o,
  output logic             last_o
);
  dp_cmd_t    ctl;
  dp_stat_t   stat;
  logic [2:0] cmd_q;
  logic       valid, active;

  stq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .cmd_i(cmd_q), .valid_i(valid), .active_i(active),
    .stat_i(stat), .ctl_o(ctl)
  );

  stq_datapath #(.Slots(TIMER_SLOTS), .TimeBits(TIME_BITS)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .stat_o(stat),
    .cmd_i, .timer_id_i, .delay_ms_i, .now_ms_i,
    .cmd_o(cmd_q), .valid_o(valid), .active_o(active),
    .strobe_o, .status_o, .slot_id_o, .timeout_ms_o,
    .queue_empty_o, .fired_o, .last_o
  );

  `STQ_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accept did not raise busy")
  `STQ_ASSERT_IMPL(a_last_strobe, last_o && strobe_o, !fired_o || status_o == StOk, "bad last")
  `STQ_ASSERT_IMPL(a_fire_ok, strobe_o && fired_o, status_o == StOk, "fired with error")
endmodule
`default_nettype wire

// ----- src/stq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module stq_datapath import stq_pkg::*; #(
  parameter int unsigned Slots    = 16,
  parameter int unsigned TimeBits = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     ctl_i,
  output dp_stat_t         stat_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [3:0]  timer_id_i,
  input  wire logic [31:0] delay_ms_i,
  input  wire logic [47:0] now_ms_i,
  output logic [2:0]       cmd_o,
  output logic             valid_o,
  output logic             active_o,
  output logic             strobe_o,
  output logic [1:0]       status_o,
  output logic [3:0]       slot_id_o,
  output logic [31:0]      timeout_ms_o,
  output logic             queue_empty_o,
  output logic             fired_o,
  output logic             last_o
);
  localparam int unsigned IW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW = $clog2(Slots + 1);
  localparam int unsigned EW = TimeBits + 1;

  logic [Slots-1:0] alloc_q, active_q;
  logic [EW-1:0]    exp_q [Slots];
  logic [IW-1:0]    ord_q [Slots];
  logic [CW-1:0]    cnt_q;

  logic [2:0]       cmd_q;
  logic [IW-1:0]    id_q;
  logic             idok_q;
  logic [EW-1:0]    newexp_q;
  logic [TimeBits-1:0] now_q;
  logic [CW-1:0]    pos_q;
  logic             found_q;
  logic [CW-1:0]    tail_q;

  // Decode of the captured word.
  logic [EW-1:0] head_exp;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] free_idx;
  logic          free_any;
  logic [IW-1:0] pos_i;
  assign pos_i    = pos_q[IW-1:0];
  assign head_exp = exp_q[ord_q[0]];
  assign cnt_m1   = cnt_q - CW'(1);

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!alloc_q[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign cmd_o    = cmd_q;
  assign valid_o  = idok_q && alloc_q[id_q];
  assign active_o = active_q[id_q];

  // Scan ends at the slot (disarm) or at the insertion point (arm).
  logic [EW-1:0] pos_exp;
  assign pos_exp = exp_q[ord_q[pos_i]];
  assign stat_o.scan_done = (pos_q >= cnt_q) ||
                            (found_q ? (newexp_q <= pos_exp) : (ord_q[pos_i] == id_q));
  assign stat_o.found        = (pos_q < cnt_q) && !found_q && (ord_q[pos_i] == id_q);
  assign stat_o.shift_done   = found_q ? (pos_q >= cnt_q) : (pos_q + CW'(1) >= cnt_q);
  assign stat_o.head_expired = (cnt_q != '0) && (head_exp <= EW'(now_q));

  // State and list updates, one entry per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q  <= '0;
      active_q <= '0;
      cnt_q    <= '0;
      strobe_o <= 1'b0;
      found_q  <= 1'b0;
      pos_q    <= '0;
    end else begin
      strobe_o <= 1'b0;
      case (ctl_i.op)
        OpLatch: begin
          cmd_q    <= cmd_i;
          id_q     <= IW'(timer_id_i);
          idok_q   <= 32'(timer_id_i) < Slots;
          now_q    <= TimeBits'(now_ms_i);
          newexp_q <= EW'(TimeBits'(now_ms_i)) + EW'(delay_ms_i);
          pos_q    <= '0;
          found_q  <= 1'b0;
        end
        OpScan: begin
          // A fire step stays at the head; otherwise walk one entry.
          if (!stat_o.scan_done && !ctl_i.fire_emit) pos_q <= pos_q + CW'(1);
        end
        OpShift: begin
          if (!found_q) begin
            // Close the gap at pos.
            if (pos_q + CW'(1) < cnt_q) begin
              ord_q[pos_i] <= ord_q[IW'(pos_q + CW'(1))];
              pos_q <= pos_q + CW'(1);
            end else begin
              cnt_q <= cnt_m1;
              active_q[id_q] <= 1'b0;
              pos_q <= '0;
              if (ctl_i.fire_emit) begin
                strobe_o     <= 1'b1;
                status_o     <= StOk;
                slot_id_o    <= 4'(id_q);
                timeout_ms_o <= '0;
                queue_empty_o <= (cnt_m1 == '0);
                fired_o      <= 1'b1;
                last_o       <= ctl_i.last || (cnt_m1 == '0);
              end
            end
          end else begin
            // Open a gap at the insertion point, from the tail down.
            if (cnt_q > pos_q) begin
              ord_q[cnt_q[IW-1:0]] <= ord_q[IW'(cnt_q - CW'(1))];
              cnt_q <= cnt_m1;
            end
          end
        end
        OpPlace: begin
          if (found_q) begin
            // cnt_q was walked down to pos; restore and insert.
            ord_q[pos_i] <= id_q;
            exp_q[id_q]  <= newexp_q;
            active_q[id_q] <= 1'b1;
            cnt_q <= tail_q + CW'(1);
          end else begin
            // Switch to arm mode; remember the count before the insert.
            found_q <= 1'b1;
            pos_q   <= '0;
            tail_q  <= cnt_q;
          end
        end
        OpFinish: begin
          strobe_o      <= 1'b1;
          status_o      <= StOk;
          slot_id_o     <= '0;
          timeout_ms_o  <= '0;
          fired_o       <= 1'b0;
          last_o        <= 1'b1;
          queue_empty_o <= (cnt_q == '0);
          case (cmd_q)
            CmdAdd: begin
              if (free_any) begin
                alloc_q[free_idx]  <= 1'b1;
                active_q[free_idx] <= 1'b0;
                slot_id_o <= 4'(free_idx);
              end else begin
                status_o <= StNoSlot;
              end
            end
            CmdSet, CmdCancel: begin
              if (!valid_o) status_o <= StBadSlot;
            end
            CmdRemove: begin
              if (valid_o) alloc_q[id_q] <= 1'b0;
              else status_o <= StBadSlot;
            end
            CmdQuery: begin
              if (cnt_q == '0) timeout_ms_o <= '1;
              else if (head_exp <= EW'(now_q)) timeout_ms_o <= '0;
              else if ((head_exp - EW'(now_q)) > EW'(33'hFFFF_FFFF)) timeout_ms_o <= '1;
              else timeout_ms_o <= 32'(head_exp - EW'(now_q));
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
      // Fire selects the head as the slot to disarm.
      if (ctl_i.op == OpScan && ctl_i.fire_emit) id_q <= ord_q[0];
    end
  end
endmodule
`default_nettype wire

// ----- src/stq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module stq_ctrl import stq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic        valid_i,
  input  wire logic        active_i,
  input  wire dp_stat_t    stat_i,
  output dp_cmd_t          ctl_o
);
  typedef enum logic [6:0] {
    SIdle   = 7'b0000001,
    SDecode = 7'b0000010,
    SScan   = 7'b0000100,
    SDel    = 7'b0001000,
    SArmGo  = 7'b0010000,
    SArm    = 7'b0100000,
    SOpen   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   fire_q, fire_d, any_q, any_d;

  assign busy_o = (state_q != SIdle);

  // Sequencer: decode, walk to the entry, close the gap, walk to the
  // insertion point, open a gap, place, then report; fire repeats the disarm.
  always_comb begin
    state_d = state_q;
    fire_d  = fire_q;
    any_d   = any_q;
    ctl_o   = '{op: OpNone, fire_emit: 1'b0, last: 1'b0};
    case (state_q)
      SIdle: begin
        if (start_i) begin
          ctl_o.op = OpLatch;
          fire_d   = 1'b0;
          state_d  = SDecode;
        end
      end
      SDecode: begin
        fire_d = (cmd_i == CmdFire);
        any_d  = 1'b0;
        if (cmd_i == CmdFire) begin
          if (stat_i.head_expired) begin
            ctl_o.op = OpScan;
            ctl_o.fire_emit = 1'b1;
            state_d = SDel;
          end else if (fire_q) begin
            // The last fired word already closed this command.
            state_d = SIdle;
          end else begin
            ctl_o.op = OpFinish;
            state_d  = SIdle;
          end
        end else if (valid_i && active_i &&
                     (cmd_i == CmdSet || cmd_i == CmdCancel || cmd_i == CmdRemove)) begin
          state_d = SScan;
        end else if (valid_i && cmd_i == CmdSet) begin
          ctl_o.op = OpPlace;
          any_d    = 1'b1;
          state_d  = SArm;
        end else begin
          ctl_o.op = OpFinish;
          state_d  = SIdle;
        end
      end
      SScan: begin
        ctl_o.op = OpScan;
        if (stat_i.scan_done) state_d = SDel;
      end
      SDel: begin
        ctl_o.op = OpShift;
        ctl_o.fire_emit = fire_q;
        ctl_o.last = !stat_i.head_expired;
        if (stat_i.shift_done) begin
          if (fire_q) begin
            state_d = SDecode;
          end else if (cmd_i == CmdSet) begin
            state_d = SArmGo;
          end else begin
            state_d = SArmGo;
          end
        end
      end
      SArmGo: begin
        if (cmd_i == CmdSet && !any_q) begin
          ctl_o.op = OpPlace;
          any_d = 1'b1;
          state_d = SArm;
        end else begin
          ctl_o.op = OpFinish;
          state_d = SIdle;
        end
      end
      SArm: begin
        ctl_o.op = OpScan;
        if (stat_i.scan_done) state_d = SOpen;
      end
      SOpen: begin
        ctl_o.op = OpShift;
        if (stat_i.shift_done) begin
          ctl_o.op = OpPlace;
          state_d  = SArmGo;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      fire_q  <= 1'b0;
      any_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fire_q  <= fire_d;
      any_q   <= any_d;
    end
  end
endmodule
`default_nettype wire
